// File: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is high.
`define STM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds across reset.
`define STM_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: src/stm_pkg.sv
// Shared types, constants and the output rounding function of the secondary transform.
`default_nettype none

package stm_pkg;

  localparam int DATA_W   = 32;
  localparam int COL_W    = 6;
  localparam int ROW_W    = 5;
  localparam int OUT_W    = 24;
  localparam int BD_W     = 5;
  localparam int CNT_W    = COL_W + 1;
  localparam int RCNT_W   = ROW_W + 1;
  localparam int CFG_IDX_W = 4;

  localparam int MAX_ROWS   = 32;
  localparam int SMALL_COLS = 16;
  localparam int SMALL_ROWS = 8;

  localparam int DEF_WIDTH        = 48;
  localparam int DEF_FULL_ROWS    = 32;
  localparam int DEF_REDUCED_ROWS = 16;
  localparam int DEF_ADST_ROWS    = 20;

  localparam logic [DATA_W-1:0] ROUND_BIAS  = 32'd64;
  localparam int                ROUND_SHIFT = 7;
  localparam int                SIGN_BIT    = 31;
  localparam logic [BD_W-1:0]   MAX_DEPTH   = 5'd16;
  localparam logic [BD_W-1:0]   RESET_DEPTH = 5'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_BIT_DEPTH      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSFORM_SIZE = 4'd1;

  localparam logic OP_COEF   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    SIZE_4X4     = 2'd0,
    SIZE_REDUCED = 2'd1,
    SIZE_FULL    = 2'd2,
    SIZE_ADST    = 2'd3
  } size_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FEED,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // One sample travelling down the cell chain.
  typedef struct packed {
    logic              valid;
    logic              first;
    logic              last;
    logic [COL_W-1:0]  col;
    logic [DATA_W-1:0] sample;
  } token_t;

  // Load request for the output stage.
  typedef struct packed {
    logic             load;
    logic [ROW_W-1:0] row;
    logic             last;
  } emit_req_t;

  // Round by 2^7 with ties away from zero, then clamp to a signed range of 8 + depth bits.
  function automatic logic signed [OUT_W-1:0] round_clamp(input logic [DATA_W-1:0] s,
                                                          input logic [BD_W-1:0] bd);
    logic [DATA_W-1:0]   t;
    logic signed [24:0]  y;
    logic signed [24:0]  pw;
    logic [BD_W-1:0]     b;
    logic [BD_W-1:0]     sh;
    b  = (bd > MAX_DEPTH) ? MAX_DEPTH : bd;
    sh = BD_W'(ROUND_SHIFT) + b;
    t  = s + ROUND_BIAS - {{(DATA_W-1){1'b0}}, s[SIGN_BIT]};
    y  = $signed(t[DATA_W-1:ROUND_SHIFT]);
    pw = 25'sd1 <<< sh;
    if (y > (pw - 25'sd1)) begin
      y = pw - 25'sd1;
    end else if (y < -pw) begin
      y = -pw;
    end
    return y[OUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: src/stm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module stm_ram #(
  parameter int DW    = stm_pkg::DATA_W,
  parameter int DEPTH = stm_pkg::DEF_WIDTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/stm_cell.sv
// One MAC cell: holds a kernel row, multiplies passing samples and forwards them.
`default_nettype none

module stm_cell #(
  parameter int WIDTH = stm_pkg::DEF_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        coef_we,
  input  logic [stm_pkg::COL_W-1:0]   coef_col,
  input  logic [stm_pkg::DATA_W-1:0]  coef_data,
  input  stm_pkg::token_t             tok_in,
  output stm_pkg::token_t             tok_out,
  output logic [stm_pkg::DATA_W-1:0]  acc
);
  import stm_pkg::*;

  localparam int AW = $clog2(WIDTH);

  token_t            tok_q;
  logic [DATA_W-1:0] coef;
  logic [DATA_W-1:0] prod;

  stm_ram #(
    .DW    (DATA_W),
    .DEPTH (WIDTH)
  ) u_row (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_col[AW-1:0]),
    .wdata (coef_data),
    .raddr (tok_in.col[AW-1:0]),
    .rdata (coef)
  );

  // Coefficient read lands together with the held sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_q.valid <= 1'b0;
    end else begin
      tok_q.valid <= tok_in.valid;
    end
    tok_q.first  <= tok_in.first;
    tok_q.last   <= tok_in.last;
    tok_q.col    <= tok_in.col;
    tok_q.sample <= tok_in.sample;
  end

  assign prod = coef * tok_q.sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (tok_q.valid) begin
      acc <= (tok_q.first ? '0 : acc) + prod;
    end
  end

  assign tok_out = tok_q;

endmodule

`default_nettype wire

// File: src/stm_emit.sv
// Output stage: rounds and clamps one row sum and holds it until taken.
`default_nettype none

module stm_emit (
  input  logic                              clk,
  input  logic                              rst,
  input  stm_pkg::emit_req_t                req,
  input  logic [stm_pkg::DATA_W-1:0]        acc,
  input  logic [stm_pkg::BD_W-1:0]          bd,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [stm_pkg::ROW_W-1:0]         out_row,
  output logic signed [stm_pkg::OUT_W-1:0]  out_value,
  output logic                              out_last,
  output logic                              free
);
  import stm_pkg::*;

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.load) begin
      out_row   <= req.row;
      out_value <= round_clamp(acc, bd);
      out_last  <= req.last;
    end
  end

endmodule

`default_nettype wire

// File: src/secondary_transform_matvec.sv
// Top level of the forward secondary transform matrix-vector engine.
// Use: one input channel (in_valid/in_stall) carries beats of opcode, row_index,
// column_index and value. Opcode 0 writes one kernel coefficient into the row
// store of cell row_index; opcode 1 writes one source sample. The sample at
// the last position of the current size starts the transform: samples stream
// from the sample RAM through a chain of 32 MAC cells, one column per cycle,
// over 16 columns for the 4x4 size and WIDTH columns otherwise. Results then
// leave on out_valid/out_stall, one row per cycle while out_stall is low, rows
// 0 upward, out_last on the final row. in_stall stays high from the starting
// beat until the last row has entered the output register; the block takes
// new input while that row still waits. A stalled output holds its beat and
// pauses the row sequencer. The config channel (cfg_valid/cfg_ready, always
// ready) sets bit_depth (index 0) and transform_size (index 1); write it only
// while idle. Synchronous reset clears control state and restores bit depth 8
// and the 4x4 size; kernel and sample stores keep whatever they held.
`default_nettype none

module secondary_transform_matvec #(
  parameter int WIDTH        = stm_pkg::DEF_WIDTH,
  parameter int FULL_ROWS    = stm_pkg::DEF_FULL_ROWS,
  parameter int REDUCED_ROWS = stm_pkg::DEF_REDUCED_ROWS,
  parameter int ADST_ROWS    = stm_pkg::DEF_ADST_ROWS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                opcode,
  input  logic [stm_pkg::ROW_W-1:0]           row_index,
  input  logic [stm_pkg::COL_W-1:0]           column_index,
  input  logic signed [stm_pkg::DATA_W-1:0]   value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [stm_pkg::ROW_W-1:0]           out_row,
  output logic signed [stm_pkg::OUT_W-1:0]    out_value,
  output logic                                out_last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [stm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [stm_pkg::DATA_W-1:0]          cfg_data
);
  import stm_pkg::*;

  localparam int AW     = $clog2(WIDTH);
  localparam int FULL_R = (FULL_ROWS > MAX_ROWS) ? MAX_ROWS : FULL_ROWS;
  localparam int RED_R  = (REDUCED_ROWS > MAX_ROWS) ? MAX_ROWS : REDUCED_ROWS;
  localparam int ADST_R = (ADST_ROWS > MAX_ROWS) ? MAX_ROWS : ADST_ROWS;
  localparam logic [CNT_W-1:0] COLS_WIDE  = CNT_W'(WIDTH);
  localparam logic [CNT_W-1:0] COLS_SMALL = CNT_W'(SMALL_COLS);

  state_t state, state_next;

  logic [BD_W-1:0]   bit_depth;
  size_t             transform_size;

  logic              in_acc;
  logic [CNT_W-1:0]  cols_now;
  logic [RCNT_W-1:0] rows_now;
  logic              coef_ok;
  logic              samp_ok;
  logic              start;

  logic [CNT_W-1:0]  cols_q;
  logic [RCNT_W-1:0] rows_q;
  logic [COL_W-1:0]  feed_cnt;
  logic              feed_rd;
  logic              feed_end;
  logic              feed_v;
  logic [COL_W-1:0]  feed_col_d;
  logic              feed_last_d;
  logic [DATA_W-1:0] samp_rdata;

  logic [ROW_W-1:0]  emit_idx;
  logic              emit_last;
  logic              out_free;
  emit_req_t         emit_req;

  token_t            tok [MAX_ROWS+1];
  logic [DATA_W-1:0] acc_arr [MAX_ROWS];
  logic              tail_done;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_depth      <= RESET_DEPTH;
      transform_size <= SIZE_4X4;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BIT_DEPTH:      bit_depth      <= cfg_data[BD_W-1:0];
        CFG_TRANSFORM_SIZE: transform_size <= size_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  // Input decode.
  assign in_acc   = in_valid && !in_stall;
  assign cols_now = (transform_size == SIZE_4X4) ? COLS_SMALL : COLS_WIDE;

  always_comb begin
    unique case (transform_size)
      SIZE_4X4:     rows_now = RCNT_W'(SMALL_ROWS);
      SIZE_REDUCED: rows_now = RCNT_W'(RED_R);
      SIZE_FULL:    rows_now = RCNT_W'(FULL_R);
      SIZE_ADST:    rows_now = RCNT_W'(ADST_R);
    endcase
  end

  assign coef_ok = in_acc && (opcode == OP_COEF) && ({1'b0, column_index} < COLS_WIDE);
  assign samp_ok = in_acc && (opcode == OP_SAMPLE) && ({1'b0, column_index} < cols_now);
  assign start   = samp_ok && ({1'b0, column_index} == cols_now - CNT_W'(1));

  stm_ram #(
    .DW    (DATA_W),
    .DEPTH (WIDTH)
  ) u_samples (
    .clk   (clk),
    .we    (samp_ok),
    .waddr (column_index[AW-1:0]),
    .wdata (value),
    .raddr (feed_cnt[AW-1:0]),
    .rdata (samp_rdata)
  );

  assign feed_end  = ({1'b0, feed_cnt} == cols_q - CNT_W'(1));
  assign emit_last = ({1'b0, emit_idx} == rows_q - RCNT_W'(1));
  assign tail_done = tok[MAX_ROWS].valid && tok[MAX_ROWS].last;

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_FEED;
      ST_FEED:  if (feed_end) state_next = ST_DRAIN;
      ST_DRAIN: if (tail_done) state_next = ST_EMIT;
      ST_EMIT:  if (out_free && emit_last) state_next = ST_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_stall      = 1'b1;
    feed_rd       = 1'b0;
    emit_req.load = 1'b0;
    emit_req.row  = emit_idx;
    emit_req.last = emit_last;
    unique case (state)
      ST_IDLE:  in_stall = 1'b0;
      ST_FEED:  feed_rd = 1'b1;
      ST_DRAIN: ;
      ST_EMIT:  emit_req.load = out_free;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      feed_v <= 1'b0;
    end else begin
      state  <= state_next;
      feed_v <= feed_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      feed_cnt <= '0;
      emit_idx <= '0;
      cols_q   <= COLS_SMALL;
      rows_q   <= RCNT_W'(SMALL_ROWS);
    end else if (start) begin
      feed_cnt <= '0;
      emit_idx <= '0;
      cols_q   <= cols_now;
      rows_q   <= rows_now;
    end else begin
      if (feed_rd) begin
        feed_cnt <= feed_cnt + COL_W'(1);
      end
      if (emit_req.load) begin
        emit_idx <= emit_idx + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    feed_col_d  <= feed_cnt;
    feed_last_d <= feed_end;
  end

  // Head of the chain: sample read data joins its column tag.
  assign tok[0].valid  = feed_v;
  assign tok[0].first  = (feed_col_d == '0);
  assign tok[0].last   = feed_last_d;
  assign tok[0].col    = feed_col_d;
  assign tok[0].sample = samp_rdata;

  for (genvar k = 0; k < MAX_ROWS; k++) begin : g_cell
    logic we_k;
    assign we_k = coef_ok && (row_index == ROW_W'(k));

    stm_cell #(
      .WIDTH (WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .coef_we   (we_k),
      .coef_col  (column_index),
      .coef_data (value),
      .tok_in    (tok[k]),
      .tok_out   (tok[k+1]),
      .acc       (acc_arr[k])
    );
  end

  stm_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .req       (emit_req),
    .acc       (acc_arr[emit_idx]),
    .bd        (bit_depth),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_row   (out_row),
    .out_value (out_value),
    .out_last  (out_last),
    .free      (out_free)
  );

endmodule

`default_nettype wire

// File: src/stm_checker.sv
// Port-level checks of the secondary transform block, bound to its top level.
`default_nettype none
`include "assert_macros.svh"

module stm_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [stm_pkg::ROW_W-1:0]         out_row,
  input logic signed [stm_pkg::OUT_W-1:0]  out_value,
  input logic                              out_last
);

  // Reset leaves the block idle with nothing to deliver.
  `STM_ASSERT_RST(a_reset_idle, rst |=> !out_valid && !in_stall, "not idle after reset")

  // A stalled result beat holds.
  `STM_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_row) && $stable(out_value) && $stable(out_last), "stalled beat changed")

  // Rows stream back to back while the transform is unloading.
  `STM_ASSERT(a_row_step, out_valid && !out_stall && !out_last |=> out_valid && (out_row == $past(out_row) + 5'd1), "row sequence broken")

  // Input waits until the final row of a transform is out.
  `STM_ASSERT(a_busy_unload, out_valid && !out_last |-> in_stall, "input taken mid unload")

endmodule

bind secondary_transform_matvec stm_checker u_stm_checker (.*);

`default_nettype wire
